/* hw/rtl/esc_pkg.sv */
package esc_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LOW  = 3'd1,
        CFG_PRESS_HIGH = 3'd2,
        CFG_PRESS_NINE = 3'd3,
        CFG_HUM        = 3'd4,
        CFG_HUM_SIX    = 3'd5
    } cfg_index_t;

    localparam logic [63:0] T_OFFSET    = 64'd128000;
    localparam logic [63:0] P_FULLSCALE = 64'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [31:0] H_OFFSET    = 32'd76800;
    localparam logic [31:0] H_CLAMP     = 32'd419430400;
    localparam logic [31:0] H_BIAS_W    = 32'd2097152;
    localparam logic [31:0] H_ROUND_X   = 32'd16384;
    localparam logic [31:0] H_BIAS_Z    = 32'd32768;
    localparam logic [31:0] H_ROUND_F   = 32'd8192;

    typedef struct packed {
        logic [19:0] adc_temperature;
        logic [19:0] adc_pressure;
        logic [15:0] adc_humidity;
    } frame_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_low;
        logic [63:0] press_high;
        logic [15:0] press_nine;
        logic [63:0] hum;
        logic [7:0]  hum_six;
    } coeffs_t;

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

/* hw/rtl/esc_frame_fifo.sv */
module esc_frame_fifo
    import esc_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output frame_t head,
    output logic   not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    frame_t        mem_reg [DEPTH];
    logic [PW:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW:0]   rd_ptr_reg, rd_ptr_next;

    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]) &&
                       (wr_ptr_reg[PW] != rd_ptr_reg[PW]);
    assign head      = mem_reg[rd_ptr_reg[PW-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (PW+1)'(push && !full);
        rd_ptr_next = rd_ptr_reg + (PW+1)'(pop && not_empty);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
        if (push && !full) begin
            mem_reg[wr_ptr_reg[PW-1:0]] <= push_data;
        end
    end

endmodule

/* hw/rtl/esc_mul.sv */
module esc_mul
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    // low 64 bits of a*b from three 32x32 partial products
    logic [63:0] a_reg, b_reg;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  phase_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] mx, my;
    logic [63:0] pp;
    logic [63:0] term;

    always_comb begin
        unique case (phase_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            default: begin mx = a_reg[63:32]; my = b_reg[31:0];  end
        endcase
        pp       = mx * my;
        term     = (phase_reg == 2'd0) ? pp : {pp[31:0], 32'd0};
        acc_next = acc_reg + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
            end else if (busy_reg) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* hw/rtl/esc_div.sv */
module esc_div
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    // signed, truncating; restoring, one bit a cycle on magnitudes
    logic [63:0] rem_reg, quo_reg, den_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] shifted;
    logic [64:0] trial;
    logic [63:0] an, ad;

    always_comb begin
        an      = dividend[63] ? (64'd0 - dividend) : dividend;
        ad      = divisor[63]  ? (64'd0 - divisor)  : divisor;
        shifted = {rem_reg[62:0], quo_reg[63]};
        trial   = {1'b0, shifted} - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            rem_reg <= '0;
            quo_reg <= an;
            den_reg <= ad;
            neg_reg <= dividend[63] ^ divisor[63];
        end else if (busy_reg) begin
            rem_reg <= trial[64] ? shifted : trial[63:0];
            quo_reg <= {quo_reg[62:0], !trial[64]};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;

endmodule

/* hw/rtl/esc_engine.sv */
module esc_engine
    import esc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  coeffs_t      coeffs,
    input  logic         frame_valid,
    input  frame_t       frame,
    output logic         frame_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [31:0]  m_temperature_centi,
    output logic [31:0]  m_pressure_q24_8,
    output logic [16:0]  m_humidity_q22_10
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_T1, ST_T2, ST_T3, ST_TEMP,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_CHK, ST_P7, ST_DIV,
        ST_P8, ST_P9, ST_P10,
        ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8, ST_OUT
    } state_t;

    state_t      state_reg;
    logic        issued_reg;
    frame_t      fr_reg;
    logic [31:0] v1_reg, tf_reg, temp_reg, hv_reg, hx_reg, hy_reg, hz_reg, press_reg;
    logic [16:0] hum_reg;
    logic [63:0] a_reg, aa_reg, b_reg, ad_reg, x_reg, p_reg, q_reg;
    logic        out_valid_reg;
    logic [31:0] out_temp_reg, out_press_reg;
    logic [16:0] out_hum_reg;

    logic [63:0] op_a, op_b, m;
    logic        is_mul, mul_start, mul_done;
    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [31:0] m32;

    // coefficient fields
    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
    logic [7:0]  h1, h3, h6;
    logic [31:0] tx, td, hsum, s15, hfin, tf5;
    logic [63:0] psum;

    assign t1 = coeffs.temp[15:0];
    assign t2 = coeffs.temp[31:16];
    assign t3 = coeffs.temp[47:32];
    assign p1 = coeffs.press_low[15:0];
    assign p2 = coeffs.press_low[31:16];
    assign p3 = coeffs.press_low[47:32];
    assign p4 = coeffs.press_low[63:48];
    assign p5 = coeffs.press_high[15:0];
    assign p6 = coeffs.press_high[31:16];
    assign p7 = coeffs.press_high[47:32];
    assign p8 = coeffs.press_high[63:48];
    assign p9 = coeffs.press_nine;
    assign h1 = coeffs.hum[7:0];
    assign h2 = coeffs.hum[23:8];
    assign h3 = coeffs.hum[31:24];
    assign h4 = coeffs.hum[47:32];
    assign h5 = coeffs.hum[63:48];
    assign h6 = coeffs.hum_six;

    assign m32 = m[31:0];

    always_comb begin
        tx   = {15'd0, fr_reg.adc_temperature[19:3]} - {15'd0, t1, 1'b0};
        td   = {16'd0, fr_reg.adc_temperature[19:4]} - {16'd0, t1};
        tf5  = {tf_reg[29:0], 2'b00} + tf_reg + 32'd128;
        hsum = {2'd0, fr_reg.adc_humidity, 14'd0} - {h4[11:0], 20'd0} - m32 + H_ROUND_X;
        s15  = 32'($signed(hz_reg) >>> 15);
        hfin = hz_reg - 32'($signed(m32) >>> 4);
        psum = p_reg + x_reg + 64'($signed(m) >>> 19);
    end

    always_comb begin
        is_mul = 1'b1;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            ST_T1:  begin op_a = sx32(tx); op_b = sx16(t2); end
            ST_T2:  begin op_a = sx32(td); op_b = sx32(td); end
            ST_T3:  begin op_a = sx32(32'($signed(x_reg[31:0]) >>> 12)); op_b = sx16(t3); end
            ST_P1:  begin op_a = a_reg;  op_b = a_reg; end
            ST_P2:  begin op_a = aa_reg; op_b = sx16(p6); end
            ST_P3:  begin op_a = a_reg;  op_b = sx16(p5); end
            ST_P4:  begin op_a = aa_reg; op_b = sx16(p3); end
            ST_P5:  begin op_a = a_reg;  op_b = sx16(p2); end
            ST_P6:  begin op_a = (64'd1 << 47) + x_reg; op_b = {48'd0, p1}; end
            ST_P7:  begin op_a = x_reg;  op_b = P_SCALE; end
            ST_P8:  begin op_a = sx16(p9); op_b = q_reg; end
            ST_P9:  begin op_a = x_reg;  op_b = q_reg; end
            ST_P10: begin op_a = sx16(p8); op_b = p_reg; end
            ST_H1:  begin op_a = sx16(h5); op_b = sx32(hv_reg); end
            ST_H2:  begin op_a = sx32(hv_reg); op_b = sx8(h6); end
            ST_H3:  begin op_a = sx32(hv_reg); op_b = {56'd0, h3}; end
            ST_H4:  begin op_a = sx32(hy_reg); op_b = sx32(hz_reg); end
            ST_H5:  begin op_a = sx32(hy_reg); op_b = sx16(h2); end
            ST_H6:  begin op_a = sx32(hx_reg); op_b = sx32(hy_reg); end
            ST_H7:  begin op_a = sx32(s15); op_b = sx32(s15); end
            ST_H8:  begin op_a = sx32(hy_reg); op_b = {56'd0, h1}; end
            default: is_mul = 1'b0;
        endcase
    end

    assign mul_start = is_mul && !issued_reg;
    assign div_start = (state_reg == ST_DIV) && !issued_reg;
    assign frame_pop = (state_reg == ST_IDLE) && frame_valid;

    esc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mul_done),
        .product (m)
    );

    esc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (ad_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (state_reg != ST_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end
            if ((is_mul && mul_done) || ((state_reg == ST_DIV) && div_done)) begin
                issued_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (frame_valid) begin
                        fr_reg    <= frame;
                        state_reg <= ST_T1;
                    end
                end
                ST_T1: if (mul_done) begin
                    v1_reg    <= 32'($signed(m32) >>> 11);
                    state_reg <= ST_T2;
                end
                ST_T2: if (mul_done) begin
                    x_reg     <= m;
                    state_reg <= ST_T3;
                end
                ST_T3: if (mul_done) begin
                    tf_reg    <= v1_reg + 32'($signed(m32) >>> 14);
                    state_reg <= ST_TEMP;
                end
                ST_TEMP: begin
                    temp_reg  <= 32'($signed(tf5) >>> 8);
                    a_reg     <= sx32(tf_reg) - T_OFFSET;
                    hv_reg    <= tf_reg - H_OFFSET;
                    state_reg <= ST_P1;
                end
                ST_P1: if (mul_done) begin
                    aa_reg    <= m;
                    state_reg <= ST_P2;
                end
                ST_P2: if (mul_done) begin
                    b_reg     <= m;
                    state_reg <= ST_P3;
                end
                ST_P3: if (mul_done) begin
                    b_reg     <= b_reg + {m[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
                    state_reg <= ST_P4;
                end
                ST_P4: if (mul_done) begin
                    x_reg     <= 64'($signed(m) >>> 8);
                    state_reg <= ST_P5;
                end
                ST_P5: if (mul_done) begin
                    x_reg     <= x_reg + {m[51:0], 12'd0};
                    state_reg <= ST_P6;
                end
                ST_P6: if (mul_done) begin
                    ad_reg    <= 64'($signed(m) >>> 33);
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    // zero divisor: pressure reads 0
                    if (ad_reg == 64'd0) begin
                        press_reg <= '0;
                        state_reg <= ST_H1;
                    end else begin
                        x_reg     <= {(P_FULLSCALE[32:0] -
                                       {13'd0, fr_reg.adc_pressure}), 31'd0} - b_reg;
                        state_reg <= ST_P7;
                    end
                end
                ST_P7: if (mul_done) begin
                    x_reg     <= m;
                    state_reg <= ST_DIV;
                end
                ST_DIV: if (div_done) begin
                    p_reg     <= div_q;
                    q_reg     <= 64'($signed(div_q) >>> 13);
                    state_reg <= ST_P8;
                end
                ST_P8: if (mul_done) begin
                    x_reg     <= m;
                    state_reg <= ST_P9;
                end
                ST_P9: if (mul_done) begin
                    x_reg     <= 64'($signed(m) >>> 25);
                    state_reg <= ST_P10;
                end
                ST_P10: if (mul_done) begin
                    press_reg <= 32'(64'($signed(psum) >>> 8) +
                                     {{44{p7[15]}}, p7, 4'd0});
                    state_reg <= ST_H1;
                end
                ST_H1: if (mul_done) begin
                    hx_reg    <= 32'($signed(hsum) >>> 15);
                    state_reg <= ST_H2;
                end
                ST_H2: if (mul_done) begin
                    hy_reg    <= 32'($signed(m32) >>> 10);
                    state_reg <= ST_H3;
                end
                ST_H3: if (mul_done) begin
                    hz_reg    <= 32'($signed(m32) >>> 11) + H_BIAS_Z;
                    state_reg <= ST_H4;
                end
                ST_H4: if (mul_done) begin
                    hy_reg    <= 32'($signed(m32) >>> 10) + H_BIAS_W;
                    state_reg <= ST_H5;
                end
                ST_H5: if (mul_done) begin
                    hy_reg    <= 32'($signed(m32 + H_ROUND_F) >>> 14);
                    state_reg <= ST_H6;
                end
                ST_H6: if (mul_done) begin
                    hz_reg    <= m32;
                    state_reg <= ST_H7;
                end
                ST_H7: if (mul_done) begin
                    hy_reg    <= 32'($signed(m32) >>> 7);
                    state_reg <= ST_H8;
                end
                ST_H8: if (mul_done) begin
                    if (hfin[31]) begin
                        hum_reg <= '0;
                    end else if (hfin > H_CLAMP) begin
                        hum_reg <= H_CLAMP[28:12];
                    end else begin
                        hum_reg <= hfin[28:12];
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_temp_reg  <= temp_reg;
                        out_press_reg <= press_reg;
                        out_hum_reg   <= hum_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_pressure_q24_8    = out_press_reg;
    assign m_humidity_q22_10   = out_hum_reg;

endmodule

/* hw/rtl/env_sensor_compensation.sv */
// Channel  | Direction | Handshake          | Word
// s_       | in        | s_valid / s_ready  | adc_temperature, adc_pressure, adc_humidity
// m_       | out       | m_valid / m_ready  | temperature_centi, pressure_q24_8, humidity_q22_10
// cfg_     | in        | cfg_wr_en          | cfg_addr selects coefficient register
//
// Each word takes 21 products on one shared 64-bit multiplier (three 32x32 partial
// products each), a bit-serial divide and 4 further steps. Words with a zero
// pressure divisor skip the divide and four products. Input words queue in a small
// FIFO while the engine works; a finished result waits in the output register while
// the engine goes on with the next word. Synchronous active-low reset clears
// control state and coefficients.
module env_sensor_compensation
    import esc_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [19:0]           s_adc_temperature,
    input  logic [19:0]           s_adc_pressure,
    input  logic [15:0]           s_adc_humidity,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_temperature_centi,
    output logic [31:0]           m_pressure_q24_8,
    output logic [16:0]           m_humidity_q22_10,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    coeffs_t coeffs_reg;
    frame_t  in_frame, head;
    logic    full, not_empty, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeffs_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_TEMP:       coeffs_reg.temp       <= cfg_wdata[47:0];
                CFG_PRESS_LOW:  coeffs_reg.press_low  <= cfg_wdata;
                CFG_PRESS_HIGH: coeffs_reg.press_high <= cfg_wdata;
                CFG_PRESS_NINE: coeffs_reg.press_nine <= cfg_wdata[15:0];
                CFG_HUM:        coeffs_reg.hum        <= cfg_wdata;
                CFG_HUM_SIX:    coeffs_reg.hum_six    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign in_frame = '{adc_temperature: s_adc_temperature,
                        adc_pressure:    s_adc_pressure,
                        adc_humidity:    s_adc_humidity};
    assign s_ready  = !full;

    esc_frame_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (in_frame),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    esc_engine u_engine (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .coeffs              (coeffs_reg),
        .frame_valid         (not_empty),
        .frame               (head),
        .frame_pop           (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_q24_8    (m_pressure_q24_8),
        .m_humidity_q22_10   (m_humidity_q22_10)
    );

endmodule

/* test/env_sensor_compensation_tb.sv */
`timescale 1ns / 1ps

module env_sensor_compensation_tb
    import esc_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] temperature_centi;
        logic [31:0] pressure_q24_8;
        logic [16:0] humidity_q22_10;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [19:0] s_adc_temperature;
    logic [19:0] s_adc_pressure;
    logic [15:0] s_adc_humidity;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_temperature_centi;
    logic [31:0] m_pressure_q24_8;
    logic [16:0] m_humidity_q22_10;
    logic        cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // local copy of the calibration registers
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_high;
    logic [15:0] cal_press_nine;
    logic [63:0] cal_hum;
    logic [7:0]  cal_hum_six;

    reading_t expected_readings[$];
    int       error_count = 0;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       idle_cycles;

    env_sensor_compensation u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_adc_temperature   (s_adc_temperature),
        .s_adc_pressure      (s_adc_pressure),
        .s_adc_humidity      (s_adc_humidity),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_q24_8    (m_pressure_q24_8),
        .m_humidity_q22_10   (m_humidity_q22_10),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                            input logic [15:0] rh);
        reading_t    r;
        logic signed [31:0] t1, t2, t3, v1, dd, v2, tf, h1, h2, h3, h4, h5, h6;
        logic signed [31:0] v, x, y, z, w, f;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, c, e, num, q;
        logic [63:0] an, ad;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        v1 = (($signed({15'd0, rt[19:3]}) - (t1 <<< 1)) * t2) >>> 11;
        dd = $signed({16'd0, rt[19:4]}) - t1;
        v2 = (((dd * dd) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        r.temperature_centi = (tf * 5 + 128) >>> 8;

        p1 = {48'd0, cal_press_low[15:0]};
        p2 = {{48{cal_press_low[31]}}, cal_press_low[31:16]};
        p3 = {{48{cal_press_low[47]}}, cal_press_low[47:32]};
        p4 = {{48{cal_press_low[63]}}, cal_press_low[63:48]};
        p5 = {{48{cal_press_high[15]}}, cal_press_high[15:0]};
        p6 = {{48{cal_press_high[31]}}, cal_press_high[31:16]};
        p7 = {{48{cal_press_high[47]}}, cal_press_high[47:32]};
        p8 = {{48{cal_press_high[63]}}, cal_press_high[63:48]};
        p9 = {{48{cal_press_nine[15]}}, cal_press_nine};
        a = {{32{tf[31]}}, tf} - 64'sd128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
        r.pressure_q24_8 = '0;
        if (a != 0) begin
            p = 64'sd1048576 - $signed({44'd0, rp});
            num = ((p <<< 31) - b) * 64'sd3125;
            // unsigned magnitudes so the most negative dividend wraps cleanly
            an = num[63] ? -num : num;
            ad = a[63] ? -a : a;
            q = $signed(an / ad);
            p = (num[63] != a[63]) ? -q : q;
            c = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            e = (p8 * p) >>> 19;
            p = ((p + c + e) >>> 8) + (p7 <<< 4);
            r.pressure_q24_8 = p[31:0];
        end

        h1 = {24'd0, cal_hum[7:0]};
        h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
        h3 = {24'd0, cal_hum[31:24]};
        h4 = {{16{cal_hum[47]}}, cal_hum[47:32]};
        h5 = {{16{cal_hum[63]}}, cal_hum[63:48]};
        h6 = {{24{cal_hum_six[7]}}, cal_hum_six};
        v = tf - 32'sd76800;
        x = (($signed({2'd0, rh, 14'd0})) - (h4 <<< 20) - h5 * v + 32'sd16384) >>> 15;
        y = (v * h6) >>> 10;
        z = ((v * h3) >>> 11) + 32'sd32768;
        w = ((y * z) >>> 10) + 32'sd2097152;
        f = (w * h2 + 32'sd8192) >>> 14;
        v = x * f;
        v = v - (((((v >>> 15) * (v >>> 15)) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        else if (v > 32'sd419430400)
            v = 32'sd419430400;
        r.humidity_q22_10 = v[28:12];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_coeff(input cfg_index_t idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_TEMP:       cal_temp       = value[47:0];
            CFG_PRESS_LOW:  cal_press_low  = value;
            CFG_PRESS_HIGH: cal_press_high = value;
            CFG_PRESS_NINE: cal_press_nine = value[15:0];
            CFG_HUM:        cal_hum        = value;
            CFG_HUM_SIX:    cal_hum_six    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [47:0] t, input logic [63:0] pl,
                             input logic [63:0] ph, input logic [15:0] p9,
                             input logic [63:0] h, input logic [7:0] h6);
        write_coeff(CFG_TEMP, {16'd0, t});
        write_coeff(CFG_PRESS_LOW, pl);
        write_coeff(CFG_PRESS_HIGH, ph);
        write_coeff(CFG_PRESS_NINE, {48'd0, p9});
        write_coeff(CFG_HUM, h);
        write_coeff(CFG_HUM_SIX, {56'd0, h6});
        cfg_wr_en <= 1'b0;
    endtask

    // drain, then give the engine time to finish anything in flight
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [19:0] rt, input logic [19:0] rp,
                              input logic [15:0] rh);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_adc_temperature <= rt;
        s_adc_pressure    <= rp;
        s_adc_humidity    <= rh;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_readings.push_back(compensate(rt, rp, rh));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected word", m_temperature_centi, 0);
                end else begin
                    reading_t want;
                    want = expected_readings.pop_front();
                    if (m_temperature_centi !== want.temperature_centi)
                        report_mismatch("temperature", m_temperature_centi,
                                        want.temperature_centi);
                    if (m_pressure_q24_8 !== want.pressure_q24_8)
                        report_mismatch("pressure", m_pressure_q24_8, want.pressure_q24_8);
                    if (m_humidity_q22_10 !== want.humidity_q22_10)
                        report_mismatch("humidity", {15'd0, m_humidity_q22_10},
                                        {15'd0, want.humidity_q22_10});
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // plausible factory calibration with random jitter
    task automatic load_typical();
        write_all({16'($urandom_range(200, 1000)), 16'($urandom_range(26000, 27000)),
                   16'($urandom_range(27000, 29000))},
                  {16'($urandom_range(2000, 9000)), 16'(-$urandom_range(100, 3000)),
                   16'(-$urandom_range(10000, 11000)), 16'($urandom_range(35000, 37000))},
                  {16'($urandom_range(2000, 15000)), 16'(-$urandom_range(1, 10)),
                   16'(-$urandom_range(5000, 8000)), 16'($urandom_range(100, 300))},
                  16'($urandom_range(3000, 5000)),
                  {16'($urandom_range(0, 60)), 16'($urandom_range(250, 400)),
                   8'($urandom_range(0, 10)), 16'($urandom_range(300, 400)),
                   8'($urandom_range(50, 100))},
                  8'($urandom_range(20, 40)));
    endtask

    task automatic test_directed_extremes();
        send_frame(20'd0, 20'd0, 16'd0);             // all-zero coefficients: zero divisor
        wait_idle();
        load_typical();
        send_frame(20'd0, 20'd0, 16'd0);
        send_frame(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_frame(20'd519888, 20'd415148, 16'd30000);
        send_frame(20'h55555, 20'hAAAAA, 16'h5555);
        send_frame(20'hAAAAA, 20'h55555, 16'hAAAA);
        send_frame(20'hFFFFF, 20'd0, 16'd65535);
        wait_idle();
        // extreme coefficients, wrapping everywhere
        write_all(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        send_frame(20'd0, 20'd0, 16'd0);
        send_frame(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        wait_idle();
        write_all(48'h8000_8000_0000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000,
                  16'h8000, 64'h8000_8000_0080_0001, 8'h80);
        send_frame(20'd0, 20'd0, 16'd0);
        send_frame(20'hFFFFF, 20'h80000, 16'h8000);
        wait_idle();
        write_all(48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                  16'h7FFF, 64'h7FFF_7FFF_FF7F_FFFF, 8'h7F);
        send_frame(20'd0, 20'hFFFFF, 16'hFFFF);
        send_frame(20'hFFFFF, 20'd0, 16'd0);
        wait_idle();
    endtask

    task automatic test_random_frames(input int count, input bit typical_cal);
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                wait_idle();
                if (typical_cal)
                    load_typical();
                else
                    write_all(48'(rand64()), rand64(), rand64(), 16'($urandom()),
                              rand64(), 8'($urandom()));
            end
            if (typical_cal)
                send_frame(20'($urandom_range(400000, 600000)),
                           20'($urandom_range(200000, 600000)), 16'($urandom()));
            else
                send_frame(20'($urandom()), 20'($urandom()), 16'($urandom()));
        end
    endtask

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_adc_temperature = '0;
        s_adc_pressure    = '0;
        s_adc_humidity    = '0;
        cfg_wr_en         = 1'b0;
        cfg_addr          = '0;
        cfg_wdata         = '0;
        cal_temp = '0; cal_press_low = '0; cal_press_high = '0;
        cal_press_nine = '0; cal_hum = '0; cal_hum_six = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_random_frames(75, 1'b1);
        send_idle_pct = 73; recv_stall_pct = 0;
        test_random_frames(75, 1'b0);
        send_idle_pct = 0; recv_stall_pct = 73;
        test_random_frames(75, 1'b1);
        send_idle_pct = 14; recv_stall_pct = 14;
        test_random_frames(75, 1'b0);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_random_frames(75, 1'b1);
        wait_idle();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* env_sensor_compensation.f */
hw/rtl/esc_pkg.sv
hw/rtl/esc_frame_fifo.sv
hw/rtl/esc_mul.sv
hw/rtl/esc_div.sv
hw/rtl/esc_engine.sv
hw/rtl/env_sensor_compensation.sv
test/env_sensor_compensation_tb.sv
